// ===== design/rans_order0_interleaved_decoder_defines.svh =====
// Assertion macros for the rANS decoder checker.
// No dependencies; included by the checker file only.
`ifndef RANS_ORDER0_INTERLEAVED_DECODER_DEFINES_SVH
`define RANS_ORDER0_INTERLEAVED_DECODER_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted
`define RANSDEC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define RANSDEC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ransdec_pkg.sv =====
// Shared types and constants for the order-0 interleaved rANS decoder.
// No dependencies.
package ransdec_pkg;

	// Command codes carried in the low bits of the input transaction
	typedef enum logic [1:0] {
		CMD_LOAD_SLOT = 2'd0,
		CMD_LOAD_LANE = 2'd1,
		CMD_DECODE    = 2'd2,
		CMD_TAIL      = 2'd3
	} cmd_t;

	localparam int unsigned STATE_W   = 32;
	localparam int unsigned WORD_W    = 16;
	localparam int unsigned SYM_W     = 8;
	localparam int unsigned FREQ_W    = 13;
	localparam int unsigned LANE_IW   = 5;   // width of lane_select field
	localparam int unsigned RENORM_SH = 15;  // renormalize below 2^15

	// One item moving down the pipeline
	typedef struct packed {
		cmd_t                 cmd;
		logic [LANE_IW-1:0]   lane;
		logic [STATE_W-1:0]   state;
		logic [WORD_W-1:0]    word;
		logic                 tail_ok;
		logic                 err;
	} item_t;

	// Lane state write from the add/renormalize stage
	typedef struct packed {
		logic                 en;
		logic [LANE_IW-1:0]   lane;
		logic [STATE_W-1:0]   state;
	} lane_wr_t;

	// Decodes still in flight, used for hazard checks
	typedef struct packed {
		logic                 dec_s1;
		logic [LANE_IW-1:0]   lane_s1;
		logic                 dec_s2;
		logic [LANE_IW-1:0]   lane_s2;
	} pend_t;

endpackage

// ===== design/ransdec_slot_ram.sv =====
// Frequency slot table: symbol, frequency and offset per slot.
// Single write port, one registered read port. No dependencies.
module ransdec_slot_ram #(
	parameter int unsigned FREQ_BITS = 12,
	parameter int unsigned DATA_W    = 33
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [FREQ_BITS-1:0] wr_addr,
	input  logic [DATA_W-1:0]    wr_data,
	input  logic                 rd_en,
	input  logic [FREQ_BITS-1:0] rd_addr,
	output logic [DATA_W-1:0]    rd_data
);

	logic [DATA_W-1:0] mem [1 << FREQ_BITS];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, held while the pipeline is stalled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/ransdec_lane_file.sv =====
// Per-lane 32-bit rANS states and the round-robin decode pointer.
// Depends on ransdec_pkg.
module ransdec_lane_file
	import ransdec_pkg::*;
#(
	parameter int unsigned LANE_COUNT = 32,
	parameter int unsigned LANE_W     = $clog2(LANE_COUNT)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load_en,
	input  logic [LANE_W-1:0]  load_lane,
	input  logic [STATE_W-1:0] load_state,
	input  logic               ptr_step,
	input  lane_wr_t           upd,
	input  logic [LANE_W-1:0]  rd_lane,
	output logic [STATE_W-1:0] rd_state,
	output logic [LANE_W-1:0]  ptr
);

	logic [STATE_W-1:0] lanes_q [LANE_COUNT];
	logic [LANE_W-1:0]  ptr_q;

	// state writes: loads at accept, decode updates from the add/renormalize stage
	always_ff @(posedge clk) begin
		for (int i = 0; i < int'(LANE_COUNT); i++) begin
			if (load_en && load_lane == LANE_W'(i)) begin
				lanes_q[i] <= load_state;
			end else if (upd.en && upd.lane[LANE_W-1:0] == LANE_W'(i)) begin
				lanes_q[i] <= upd.state;
			end
		end
	end

	// round-robin pointer, wraps at LANE_COUNT
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (ptr_step) begin
			if (ptr_q == LANE_W'(LANE_COUNT - 1)) begin
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	assign rd_state = lanes_q[rd_lane];
	assign ptr      = ptr_q;

endmodule

// ===== design/ransdec_datapath.sv =====
// Decode datapath: multiply stage, add/renormalize stage, output register.
// Depends on ransdec_pkg; slot data arrives from the slot RAM in stage 1.
module ransdec_datapath
	import ransdec_pkg::*;
#(
	parameter int unsigned FREQ_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_valid,
	input  item_t                in_item,
	input  logic [SYM_W-1:0]     slot_sym,
	input  logic [FREQ_W-1:0]    slot_freq,
	input  logic [FREQ_BITS-1:0] slot_offs,
	output lane_wr_t             upd,
	output pend_t                pend,
	output logic                 out_valid,
	output logic [SYM_W-1:0]     out_sym,
	output logic                 out_consumed,
	output logic                 out_err
);

	localparam int unsigned QW = STATE_W - FREQ_BITS;
	localparam int unsigned PW = QW + FREQ_W;

	logic                 v_s1, v_s2, out_v_q;
	item_t                it_s1, it_s2;
	logic [STATE_W-1:0]   prod_s2;
	logic [FREQ_BITS-1:0] offs_s2;
	logic [SYM_W-1:0]     sym_s2;
	logic [SYM_W-1:0]     sym_q;
	logic                 consumed_q, err_q;

	logic [PW-1:0]        prod_full;
	logic [SYM_W-1:0]     sym_sel;
	logic [STATE_W-1:0]   nx;
	logic                 low;
	logic [STATE_W-1:0]   new_state;
	logic                 is_dec_s2;

	// stage 1: frequency times the upper state bits
	assign prod_full = slot_freq * it_s1.state[STATE_W-1:FREQ_BITS];

	always_comb begin
		case (it_s1.cmd)
			CMD_DECODE: sym_sel = slot_sym;
			CMD_TAIL:   sym_sel = it_s1.tail_ok ? slot_sym : '0;
			default:    sym_sel = '0;
		endcase
	end

	// stage 2: add offset, renormalize with one stream word
	assign nx        = prod_s2 + STATE_W'(offs_s2);
	assign low       = (nx[STATE_W-1:RENORM_SH] == '0);
	assign new_state = low ? {nx[WORD_W-1:0], it_s2.word} : nx;
	assign is_dec_s2 = (it_s2.cmd == CMD_DECODE);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= in_valid;
			v_s2    <= v_s1;
			out_v_q <= v_s2;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			it_s1      <= in_item;
			it_s2      <= it_s1;
			prod_s2    <= STATE_W'(prod_full);
			offs_s2    <= slot_offs;
			sym_s2     <= sym_sel;
			sym_q      <= sym_s2;
			consumed_q <= is_dec_s2 && low;
			err_q      <= it_s2.err;
		end
	end

	// lane write-back as the item leaves stage 2
	assign upd.en    = adv && v_s2 && is_dec_s2;
	assign upd.lane  = it_s2.lane;
	assign upd.state = new_state;

	assign pend.dec_s1  = v_s1 && (it_s1.cmd == CMD_DECODE);
	assign pend.lane_s1 = it_s1.lane;
	assign pend.dec_s2  = v_s2 && is_dec_s2;
	assign pend.lane_s2 = it_s2.lane;

	assign out_valid    = out_v_q;
	assign out_sym      = sym_q;
	assign out_consumed = consumed_q;
	assign out_err      = err_q;

endmodule

// ===== design/rans_order0_interleaved_decoder.sv =====
// Top level of the order-0 interleaved rANS decoder: stage 1, stage 2, output register.
// Throughput: one item per cycle while neither back-pressure nor a lane hazard stalls it.
// A load, decode or tail that touches a lane whose decode is still in the multiply or
// add stage waits until that decode is written back; the loop is lane state -> slot
// RAM read -> multiply -> add. Reset clears pipeline valids and the lane pointer;
// slot table and lane states are undefined until loaded.
module rans_order0_interleaved_decoder
	import ransdec_pkg::*;
#(
	parameter int unsigned FREQ_BITS  = 12,
	parameter int unsigned LANE_COUNT = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// command[1:0], slot_index[13:2], slot_symbol[21:14], slot_frequency[34:22],
	// slot_offset[46:35], lane_select[51:47], initial_state[83:52],
	// next_word[99:84], zero pad[103:100]
	input  logic [103:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// symbol_out[7:0], word_consumed[8], state_error[9], zero pad[15:10]
	output logic [15:0]  m_axis_tdata
);

	localparam int unsigned LANE_W = $clog2(LANE_COUNT);
	localparam int unsigned SLOT_W = SYM_W + FREQ_W + FREQ_BITS;

	// unpacked input fields
	cmd_t               cmd;
	logic [11:0]        slot_index;
	logic [SYM_W-1:0]   slot_symbol;
	logic [FREQ_W-1:0]  slot_frequency;
	logic [11:0]        slot_offset;
	logic [LANE_IW-1:0] lane_select;
	logic [STATE_W-1:0] initial_state;
	logic [WORD_W-1:0]  next_word;

	logic               adv, acc, hazard, lane_ok, touches;
	logic [LANE_W-1:0]  ptr, rd_lane;
	logic [STATE_W-1:0] rd_state;
	item_t              item;
	lane_wr_t           upd;
	pend_t              pend;
	logic [SLOT_W-1:0]  slot_rd;
	logic               out_valid, out_consumed, out_err;
	logic [SYM_W-1:0]   out_sym;

	assign cmd            = cmd_t'(s_axis_tdata[1:0]);
	assign slot_index     = s_axis_tdata[13:2];
	assign slot_symbol    = s_axis_tdata[21:14];
	assign slot_frequency = s_axis_tdata[34:22];
	assign slot_offset    = s_axis_tdata[46:35];
	assign lane_select    = s_axis_tdata[51:47];
	assign initial_state  = s_axis_tdata[83:52];
	assign next_word      = s_axis_tdata[99:84];

	// lane addressed by this item and hazard against in-flight decodes
	assign lane_ok = ({1'b0, lane_select} < (LANE_IW + 1)'(LANE_COUNT));
	assign rd_lane = (cmd == CMD_DECODE) ? ptr : lane_select[LANE_W-1:0];

	always_comb begin
		case (cmd)
			CMD_DECODE:              touches = 1'b1;
			CMD_LOAD_LANE, CMD_TAIL: touches = lane_ok;
			default:                 touches = 1'b0;
		endcase
	end

	assign hazard = touches &&
		((pend.dec_s1 && pend.lane_s1[LANE_W-1:0] == rd_lane) ||
		 (pend.dec_s2 && pend.lane_s2[LANE_W-1:0] == rd_lane));

	// whole pipeline moves when the output register is empty or its result is taken
	assign adv           = !out_valid || m_axis_tready;
	assign s_axis_tready = adv && !hazard;
	assign acc           = s_axis_tvalid && s_axis_tready;

	// item entering stage 1
	assign item.cmd     = cmd;
	assign item.lane    = LANE_IW'(rd_lane);
	assign item.state   = rd_state;
	assign item.word    = next_word;
	assign item.tail_ok = lane_ok;
	assign item.err     = (cmd == CMD_LOAD_LANE) &&
	                      (initial_state[STATE_W-1:RENORM_SH] == '0);

	ransdec_lane_file #(
		.LANE_COUNT (LANE_COUNT),
		.LANE_W     (LANE_W)
	) u_lanes (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_en    (acc && cmd == CMD_LOAD_LANE && lane_ok),
		.load_lane  (lane_select[LANE_W-1:0]),
		.load_state (initial_state),
		.ptr_step   (acc && cmd == CMD_DECODE),
		.upd        (upd),
		.rd_lane    (rd_lane),
		.rd_state   (rd_state),
		.ptr        (ptr)
	);

	ransdec_slot_ram #(
		.FREQ_BITS (FREQ_BITS),
		.DATA_W    (SLOT_W)
	) u_slots (
		.clk     (clk),
		.wr_en   (acc && cmd == CMD_LOAD_SLOT),
		.wr_addr (FREQ_BITS'(slot_index)),
		.wr_data ({slot_symbol, slot_frequency, FREQ_BITS'(slot_offset)}),
		.rd_en   (adv),
		.rd_addr (rd_state[FREQ_BITS-1:0]),
		.rd_data (slot_rd)
	);

	ransdec_datapath #(
		.FREQ_BITS (FREQ_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.in_valid     (acc),
		.in_item      (item),
		.slot_sym     (slot_rd[SLOT_W-1 -: SYM_W]),
		.slot_freq    (slot_rd[FREQ_BITS +: FREQ_W]),
		.slot_offs    (slot_rd[FREQ_BITS-1:0]),
		.upd          (upd),
		.pend         (pend),
		.out_valid    (out_valid),
		.out_sym      (out_sym),
		.out_consumed (out_consumed),
		.out_err      (out_err)
	);

	assign m_axis_tvalid = out_valid;
	assign m_axis_tdata  = {6'd0, out_err, out_consumed, out_sym};

endmodule

// ===== design/ransdec_checker.sv =====
// Port-level checker for the rANS decoder, bound to the top level.
// Depends on rans_order0_interleaved_decoder_defines.svh.
`include "rans_order0_interleaved_decoder_defines.svh"

module ransdec_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [15:0]  m_axis_tdata
);

	logic [2:0] inflight_q;
	logic       s_acc, m_acc;

	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign m_acc = m_axis_tvalid && m_axis_tready;

	// transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (s_acc && !m_acc) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (m_acc && !s_acc) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	`RANSDEC_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
	`RANSDEC_ASSERT(a_stall_in, clk, arst_n, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "input taken while output stalled")
	`RANSDEC_ASSERT(a_depth, clk, arst_n, inflight_q <= 3'd3, "more than three transactions in flight")
	`RANSDEC_ASSERT(a_no_orphan, clk, arst_n, m_axis_tvalid |-> inflight_q != 3'd0, "result without an accepted transaction")
	`RANSDEC_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |-> m_axis_tvalid !== 1'b1, "result valid during reset")

endmodule

bind rans_order0_interleaved_decoder ransdec_checker u_ransdec_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
